@@ rtl/m7681_pkg.sv @@
// Package with operation codes and arithmetic constants of the modulo-7681 arithmetic unit.
`default_nettype none

package m7681_pkg;

  localparam logic [2:0] OP_MONT_MUL  = 3'd0;
  localparam logic [2:0] OP_FROM_MONT = 3'd1;
  localparam logic [2:0] OP_ADD       = 3'd2;
  localparam logic [2:0] OP_SUB       = 3'd3;
  localparam logic [2:0] OP_REDUCE    = 3'd4;

  localparam int unsigned ModQ         = 7681;
  localparam int unsigned MontQinv     = 7679;
  localparam int unsigned RinvFactor   = 900;
  localparam int unsigned BarrettMul   = 17474;
  localparam int unsigned BarrettShift = 27;
  // floor(2^37 / 7681), used to estimate quotients of values below 2^25.
  localparam int unsigned RecipMul     = 17893367;
  localparam int unsigned RecipShift   = 37;

  localparam int unsigned NumStages = 6;

  localparam int unsigned ResW = 17;

  typedef logic signed [ResW-1:0] res_t;

endpackage

`default_nettype wire

@@ rtl/mod_7681_arith_unit.sv @@
// Top level of the pipelined modulo-7681 arithmetic unit.
`default_nettype none

// A transaction is taken at every clock edge with start_i high; busy_o is always low, so one
// transaction can enter each cycle. Its result appears on result_value_o with done_o high,
// in order, for one cycle. The six register stages are an input register and the
// chain of three dependent multiplications (operand product, Montgomery or reciprocal
// estimate, quotient times 7681), each followed by its own register, then the final add and
// the one-step correction. Codes 5 to 7 return zero.

module mod_7681_arith_unit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [2:0]            operation_i,
  input  wire logic signed [15:0]    operand_a_i,
  input  wire logic signed [15:0]    operand_b_i,
  output logic                       busy_o,
  output logic                       done_o,
  output m7681_pkg::res_t            result_value_o
);

  import m7681_pkg::*;

  logic                   accept;
  logic [NumStages-1:0]   vld_q;
  logic [NumStages-1:0]   vld_d;

  logic [2:0]             s1_op_q, s2_op_q, s3_op_q, s4_op_q, s5_op_q;
  logic signed [15:0]     s1_a_q, s2_a_q, s3_a_q, s4_a_q;
  logic signed [15:0]     s1_b_q;
  logic [15:0]            s1_absa_q;
  logic [15:0]            s1_absa_d;
  logic                   s1_neg_q, s2_neg_q, s3_neg_q, s4_neg_q, s5_neg_q;
  logic signed [16:0]     s1_as_q, s1_as_d;
  logic signed [16:0]     s2_as_q, s2_as_d, s3_as_q, s4_as_q, s5_as_q;

  logic signed [16:0]     m1_x;
  logic signed [15:0]     m1_y;
  logic signed [32:0]     s2_prod;
  logic signed [32:0]     s3_prod_q, s4_prod_q;

  logic signed [26:0]     m2_x;
  logic signed [25:0]     m2_y;
  logic signed [52:0]     s3_est;

  logic signed [16:0]     m3_x;
  logic signed [14:0]     m3_y;
  logic signed [31:0]     s4_kq;

  logic signed [33:0]     s5_diff_d, s5_diff_q;

  logic [13:0]            r0;
  logic [13:0]            r1;
  logic signed [16:0]     r4;
  res_t                   res_d, res_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign vld_d = {vld_q[NumStages-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s1_absa_d = operand_a_i[15] ? 16'(-operand_a_i) : 16'(operand_a_i);
  assign s1_as_d   = (operation_i == OP_SUB) ?
                     (17'(operand_a_i) - 17'(operand_b_i)) :
                     (17'(operand_a_i) + 17'(operand_b_i));

  always_ff @(posedge clk_i) begin
    s1_op_q   <= operation_i;
    s1_a_q    <= operand_a_i;
    s1_b_q    <= operand_b_i;
    s1_absa_q <= s1_absa_d;
    s1_neg_q  <= operand_a_i[15];
    s1_as_q   <= s1_as_d;
  end

  always_comb begin
    case (s1_op_q)
      OP_MONT_MUL: begin
        m1_x = 17'(s1_a_q);
        m1_y = s1_b_q;
      end
      OP_FROM_MONT: begin
        m1_x = $signed({1'b0, s1_absa_q});
        m1_y = 16'(RinvFactor);
      end
      default: begin
        m1_x = 17'(s1_a_q);
        m1_y = 16'(BarrettMul);
      end
    endcase
  end

  m7681_mul #(.AW(17), .BW(16)) u_mul_op (
    .clk_i (clk_i),
    .a_i   (m1_x),
    .b_i   (m1_y),
    .p_o   (s2_prod)
  );

  always_comb begin
    if (s1_as_q >= $signed(17'(ModQ))) begin
      s2_as_d = s1_as_q - $signed(17'(ModQ));
    end else if (s1_as_q < 0) begin
      s2_as_d = s1_as_q + $signed(17'(ModQ));
    end else begin
      s2_as_d = s1_as_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_op_q  <= s1_op_q;
    s2_a_q   <= s1_a_q;
    s2_neg_q <= s1_neg_q;
    s2_as_q  <= s2_as_d;
  end

  always_comb begin
    if (s2_op_q == OP_MONT_MUL) begin
      m2_x = $signed({11'd0, s2_prod[15:0]});
      m2_y = 26'(MontQinv);
    end else begin
      m2_x = $signed({2'd0, s2_prod[24:0]});
      m2_y = 26'(RecipMul);
    end
  end

  m7681_mul #(.AW(27), .BW(26)) u_mul_est (
    .clk_i (clk_i),
    .a_i   (m2_x),
    .b_i   (m2_y),
    .p_o   (s3_est)
  );

  always_ff @(posedge clk_i) begin
    s3_op_q   <= s2_op_q;
    s3_a_q    <= s2_a_q;
    s3_neg_q  <= s2_neg_q;
    s3_as_q   <= s2_as_q;
    s3_prod_q <= s2_prod;
  end

  always_comb begin
    case (s3_op_q)
      OP_MONT_MUL:  m3_x = $signed({1'b0, s3_est[15:0]});
      OP_FROM_MONT: m3_x = $signed({5'd0, s3_est[RecipShift+11:RecipShift]});
      default:      m3_x = 17'(s3_prod_q >>> BarrettShift);
    endcase
    m3_y = 15'(ModQ);
  end

  m7681_mul #(.AW(17), .BW(15)) u_mul_q (
    .clk_i (clk_i),
    .a_i   (m3_x),
    .b_i   (m3_y),
    .p_o   (s4_kq)
  );

  always_ff @(posedge clk_i) begin
    s4_op_q   <= s3_op_q;
    s4_a_q    <= s3_a_q;
    s4_neg_q  <= s3_neg_q;
    s4_as_q   <= s3_as_q;
    s4_prod_q <= s3_prod_q;
  end

  always_comb begin
    case (s4_op_q)
      OP_MONT_MUL:  s5_diff_d = 34'(s4_prod_q) + 34'(s4_kq);
      OP_FROM_MONT: s5_diff_d = 34'(s4_prod_q) - 34'(s4_kq);
      default:      s5_diff_d = 34'(s4_a_q) - 34'(s4_kq);
    endcase
  end

  always_ff @(posedge clk_i) begin
    s5_op_q   <= s4_op_q;
    s5_neg_q  <= s4_neg_q;
    s5_as_q   <= s4_as_q;
    s5_diff_q <= s5_diff_d;
  end

  assign r0 = s5_diff_q[13:0];
  assign r1 = (r0 >= 14'(ModQ)) ? (r0 - 14'(ModQ)) : r0;
  assign r4 = s5_diff_q[16:0];

  always_comb begin
    case (s5_op_q)
      OP_MONT_MUL:  res_d = s5_diff_q[32:16];
      OP_FROM_MONT: res_d = s5_neg_q ? -$signed({3'd0, r1}) : $signed({3'd0, r1});
      OP_ADD:       res_d = s5_as_q;
      OP_SUB:       res_d = s5_as_q;
      OP_REDUCE:    res_d = (r4 == $signed(17'(ModQ))) ? '0 : r4;
      default:      res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o         = vld_q[NumStages-1];
  assign result_value_o = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##6 done_o)
    else $error("accepted transaction did not complete after six cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 6))
    else $error("result strobe without a matching transaction");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ($past(operation_i, 6) > OP_REDUCE) |-> result_value_o == '0)
    else $error("unused operation code gave a nonzero result");

endmodule

`default_nettype wire

@@ rtl/m7681_mul.sv @@
// Signed multiplier with a registered product.
`default_nettype none

module m7681_mul #(
  parameter int AW = 17,
  parameter int BW = 16
) (
  input  wire logic                    clk_i,
  input  wire logic signed [AW-1:0]    a_i,
  input  wire logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0]      p_o
);

  logic signed [AW+BW-1:0] p_d;
  logic signed [AW+BW-1:0] p_q;

  assign p_d = AW'(a_i) * BW'(b_i) ;
  assign p_o = p_q;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

endmodule

`default_nettype wire
